[rtl/box_average_downscaler_assert.svh]
// Assertion macros for the downscaler RTL.
`ifndef BOX_AVERAGE_DOWNSCALER_ASSERT_SVH
`define BOX_AVERAGE_DOWNSCALER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define BXD_ASSERT_IMM(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("box_average_downscaler: check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define BXD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("box_average_downscaler: check failed");

`endif

[rtl/bxd_pkg.sv]
// Shared constants and types of the box-average downscaler.
package bxd_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_FACTOR   = 16;
    localparam int HEIGHT_LIMIT = 16384;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);           // output column index
    localparam int WID_W   = 13;                          // frame_width register
    localparam int HGT_W   = 15;                          // frame_height register
    localparam int FAC_W   = 5;                           // reduce_factor register
    localparam int ROW_W   = $clog2(HEIGHT_LIMIT);        // input row index
    localparam int PHASE_W = $clog2(MAX_FACTOR);
    localparam int RUN_W   = PHASE_W + PIX_W;             // sum across one block row
    localparam int SUM_W   = 2 * PHASE_W + PIX_W;         // sum of one whole block
    localparam int AREA_W  = 2 * PHASE_W + 1;             // f*f up to MAX_FACTOR**2
    localparam int QSTEP_W = $clog2(PIX_W);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = HGT_W;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [FAC_W-1:0] FACTOR_RESET = 5'd2;
    localparam logic [WID_W-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 15'd1024;

    typedef struct packed {
        logic              start;
        logic              ack;
        logic [SUM_W-1:0]  dividend;
        logic [AREA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             valid;
        logic [PIX_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/bxd_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
module bxd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bxd_div.sv]
// Restoring divider, one quotient bit per cycle, result held until acknowledged.
module bxd_div import bxd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic               r_busy, n_busy;
    logic               r_valid, n_valid;
    logic [QSTEP_W-1:0] r_step, n_step;
    logic [SUM_W-1:0]   r_rem, n_rem;
    logic [SUM_W-1:0]   r_dsh, n_dsh;
    logic [PIX_W-1:0]   r_q, n_q;

    always_comb begin
        n_busy  = r_busy;
        n_valid = r_valid;
        n_step  = r_step;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        if (i_req.ack) begin
            n_valid = 1'b0;
        end
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = QSTEP_W'(PIX_W - 1);
            n_rem  = i_req.dividend;
            // divisor aligned to the top quotient bit
            n_dsh  = SUM_W'({i_req.divisor, {(PIX_W-1){1'b0}}});
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_q   = {r_q[PIX_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[PIX_W-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy  = 1'b0;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_step  <= n_step;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_rsp.busy  = r_busy | r_valid;
    assign o_rsp.valid = r_valid;
    assign o_rsp.quot  = r_q;

endmodule

[rtl/box_average_downscaler.sv]
// Top level of the box-average downscaler: position tracking, column-sum RMW, output.
//
// Grey 8-bit pixels arrive in raster order and every whole f-by-f block of the
// frame gives one output pixel, the rounded mean (sum + floor(f*f/2)) / (f*f);
// columns and rows past the last whole block are dropped. A pixel that closes
// a block segment in a row holds the input while the merge state does the
// read-modify-write of its output column's partial sum in the column-sum RAM,
// and a pixel that closes a whole block holds it further through the divide
// state for the bit-serial divider (eight quotient steps, then the hand-over of
// the mean to the output register), longer if the previous result has not been
// taken yet. The column-sum RAM needs no clearing after reset: the top row of
// every block row writes its entry without using the value read back.
// Writing any of the mapped configuration registers restarts the frame.
`include "box_average_downscaler_assert.svh"

module box_average_downscaler import bxd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // pixel input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel_in
    // block mean output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] pixel_out
    output logic                 m_axis_tlast,   // row_end
    output logic                 m_axis_tuser    // [0] frame_end
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MERGE = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;

    // configuration
    logic [FAC_W-1:0] r_factor;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    // frame position
    logic [1:0]       r_state, n_state;
    logic [COL_W-1:0] r_in_column, n_in_column;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [PHASE_W-1:0] r_phase_across, n_phase_across;
    logic [PHASE_W-1:0] r_phase_down, n_phase_down;
    logic [COL_W-1:0] r_out_column, n_out_column;
    logic [WID_W-1:0] r_col_base, n_col_base;   // first input column of current block
    logic [HGT_W-1:0] r_row_base, n_row_base;   // first input row of current block row
    logic [RUN_W-1:0] r_run_sum, n_run_sum;

    // block segment waiting for its column-sum update
    logic [SUM_W-1:0] r_acc, n_acc;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_first, n_first;
    logic             r_last, n_last;
    logic             r_rend, n_rend;
    logic             r_fend, n_fend;

    // output register
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pix, n_out_pix;
    logic             r_out_rend, n_out_rend;
    logic             r_out_fend, n_out_fend;

    // effective (clamped) settings
    logic [FAC_W-1:0]    w_f;
    logic [WID_W-1:0]    w_w;
    logic [HGT_W-1:0]    w_h;
    logic [2*FAC_W-1:0]  w_area_full;
    logic [AREA_W-1:0]   w_area;

    logic                s_accept;
    logic                cfg_write;
    logic                w_in_range;
    logic                w_blk_end;
    logic                w_row_done;
    logic [WID_W:0]      w_col_next;    // end of current block plus one more block
    logic [HGT_W:0]      w_row_next;
    logic [SUM_W-1:0]    w_rd_data;
    logic [SUM_W-1:0]    w_merged;
    logic                w_ram_re;
    logic                w_ram_we;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign w_f = (r_factor == '0) ? FAC_W'(1) :
                 (r_factor > FAC_W'(MAX_FACTOR)) ? FAC_W'(MAX_FACTOR) : r_factor;
    assign w_w = (r_width == '0) ? WID_W'(1) :
                 (r_width > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_width;
    assign w_h = (r_height == '0) ? HGT_W'(1) :
                 (r_height > HGT_W'(HEIGHT_LIMIT)) ? HGT_W'(HEIGHT_LIMIT) : r_height;
    assign w_area_full = w_f * w_f;
    assign w_area      = w_area_full[AREA_W-1:0];

    assign o_cfg_ready   = 1'b1;
    assign cfg_write     = i_cfg_valid && (i_cfg_index == REG_FACTOR ||
                           i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // a pixel counts only if its whole block fits inside the frame
    assign w_in_range = ({1'b0, r_col_base} + {{(WID_W+1-FAC_W){1'b0}}, w_f}
                         <= {1'b0, w_w})
                     && ({1'b0, r_row_base} + {{(HGT_W+1-FAC_W){1'b0}}, w_f}
                         <= {1'b0, w_h});
    assign w_blk_end  = w_in_range && (r_phase_across == PHASE_W'(w_f - 1'b1));
    assign w_row_done = ({1'b0, r_in_column} + 1'b1) >= w_w;
    // no further whole block to the right / below means row end / frame end
    assign w_col_next = {1'b0, r_col_base} + {{(WID_W-FAC_W){1'b0}}, w_f, 1'b0};
    assign w_row_next = {1'b0, r_row_base} + {{(HGT_W-FAC_W){1'b0}}, w_f, 1'b0};

    assign w_merged = r_first ? r_acc : (w_rd_data + r_acc);
    assign w_ram_re = s_accept && w_blk_end;
    assign w_ram_we = (r_state == S_MERGE);

    always_comb begin
        w_div_req.start    = (r_state == S_MERGE) && r_last;
        w_div_req.ack      = 1'b0;
        w_div_req.dividend = w_merged + SUM_W'(w_area >> 1);
        w_div_req.divisor  = w_area;

        n_state        = r_state;
        n_in_column    = r_in_column;
        n_in_row       = r_in_row;
        n_phase_across = r_phase_across;
        n_phase_down   = r_phase_down;
        n_out_column   = r_out_column;
        n_col_base     = r_col_base;
        n_row_base     = r_row_base;
        n_run_sum      = r_run_sum;
        n_acc          = r_acc;
        n_col          = r_col;
        n_first        = r_first;
        n_last         = r_last;
        n_rend         = r_rend;
        n_fend         = r_fend;
        n_out_valid    = r_out_valid;
        n_out_pix      = r_out_pix;
        n_out_rend     = r_out_rend;
        n_out_fend     = r_out_fend;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (w_in_range) begin
                        if (w_blk_end) begin
                            n_acc   = SUM_W'(r_run_sum) + SUM_W'(s_axis_tdata);
                            n_col   = r_out_column;
                            n_first = (r_phase_down == '0);
                            n_last  = (r_phase_down == PHASE_W'(w_f - 1'b1));
                            n_rend  = (w_col_next > {1'b0, w_w});
                            n_fend  = n_rend && (w_row_next > {1'b0, w_h});
                            n_run_sum      = '0;
                            n_out_column   = r_out_column + 1'b1;
                            n_col_base     = r_col_base + WID_W'(w_f);
                            n_phase_across = '0;
                            n_state        = S_MERGE;
                        end else begin
                            n_run_sum      = r_run_sum + RUN_W'(s_axis_tdata);
                            n_phase_across = r_phase_across + 1'b1;
                        end
                    end
                    if (w_row_done) begin
                        n_in_column    = '0;
                        n_phase_across = '0;
                        n_out_column   = '0;
                        n_col_base     = '0;
                        n_run_sum      = '0;
                        if ({1'b0, r_phase_down} + 1'b1 >= w_f) begin
                            n_phase_down = '0;
                            n_row_base   = r_row_base + HGT_W'(w_f);
                        end else begin
                            n_phase_down = r_phase_down + 1'b1;
                        end
                        if ({1'b0, r_in_row} + 1'b1 >= w_h) begin
                            n_in_row     = '0;
                            n_phase_down = '0;
                            n_row_base   = '0;
                        end else begin
                            n_in_row = r_in_row + 1'b1;
                        end
                    end else begin
                        n_in_column = r_in_column + 1'b1;
                    end
                end
            end
            S_MERGE: begin
                n_state = r_last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_rsp.valid && (!r_out_valid || m_axis_tready)) begin
                    w_div_req.ack = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_pix     = w_div_rsp.quot;
                    n_out_rend    = r_rend;
                    n_out_fend    = r_fend;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a write to any mapped register restarts the frame
        if (cfg_write) begin
            n_in_column    = '0;
            n_in_row       = '0;
            n_phase_across = '0;
            n_phase_down   = '0;
            n_out_column   = '0;
            n_col_base     = '0;
            n_row_base     = '0;
            n_run_sum      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor       <= FACTOR_RESET;
            r_width        <= WIDTH_RESET;
            r_height       <= HEIGHT_RESET;
            r_state        <= S_IDLE;
            r_in_column    <= '0;
            r_in_row       <= '0;
            r_phase_across <= '0;
            r_phase_down   <= '0;
            r_out_column   <= '0;
            r_col_base     <= '0;
            r_row_base     <= '0;
            r_run_sum      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_FACTOR: r_factor <= i_cfg_data[FAC_W-1:0];
                    REG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                    default: ;
                endcase
            end
            r_state        <= n_state;
            r_in_column    <= n_in_column;
            r_in_row       <= n_in_row;
            r_phase_across <= n_phase_across;
            r_phase_down   <= n_phase_down;
            r_out_column   <= n_out_column;
            r_col_base     <= n_col_base;
            r_row_base     <= n_row_base;
            r_run_sum      <= n_run_sum;
            r_out_valid    <= n_out_valid;
        end
        r_acc      <= n_acc;
        r_col      <= n_col;
        r_first    <= n_first;
        r_last     <= n_last;
        r_rend     <= n_rend;
        r_fend     <= n_fend;
        r_out_pix  <= n_out_pix;
        r_out_rend <= n_out_rend;
        r_out_fend <= n_out_fend;
    end

    // partial block sums, one entry per output column
    bxd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_sums (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_col),
        .i_wdata (w_merged),
        .i_re    (w_ram_re),
        .i_raddr (r_out_column),
        .o_rdata (w_rd_data)
    );

    bxd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_rend;
    assign m_axis_tuser  = r_out_fend;

    `BXD_ASSERT_NXT(a_blk_end_merges, s_accept && w_blk_end, r_state == S_MERGE)
    `BXD_ASSERT_NXT(a_last_row_divides, (r_state == S_MERGE) && r_last, w_div_rsp.busy)
    `BXD_ASSERT_IMM(a_phase_in_block, 1'b1, {1'b0, r_phase_across} < w_f)
    `BXD_ASSERT_IMM(a_result_from_div, $rose(m_axis_tvalid), $past(r_state == S_DIV))

endmodule

[dv/block_mean_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the box-average downscaler: predicts block means and compares them.
module block_mean_checker import bxd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  logic [PIX_W-1:0]     i_pix_data,
    input  logic                 i_mean_valid,
    input  logic                 i_mean_ready,
    input  logic [PIX_W-1:0]     i_mean_data,
    input  logic                 i_mean_last,
    input  logic                 i_mean_user,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic             frame_end;
    } t_block_mean;

    logic [FAC_W-1:0]   factor_reg;
    logic [WID_W-1:0]   width_reg;
    logic [HGT_W-1:0]   height_reg;
    logic [SUM_W-1:0]   col_sum [MAX_WIDTH];
    logic [RUN_W-1:0]   run_sum;
    logic [WID_W-1:0]   in_col;
    logic [HGT_W-1:0]   in_row;
    logic [PHASE_W-1:0] phase_x;
    logic [PHASE_W-1:0] phase_y;
    logic [COL_W-1:0]   out_col;
    t_block_mean        means_due [$];

    function automatic int clamp_to(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic restart_frame();
        run_sum = '0;
        in_col  = '0;
        in_row  = '0;
        phase_x = '0;
        phase_y = '0;
        out_col = '0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DAT_W-1:0] data);
        logic hit;
        hit = 1'b1;
        unique case (idx)
            REG_FACTOR: factor_reg = data[FAC_W-1:0];
            REG_WIDTH:  width_reg  = data[WID_W-1:0];
            REG_HEIGHT: height_reg = data[HGT_W-1:0];
            default:    hit = 1'b0;
        endcase
        if (hit) restart_frame();
    endtask

    // One input pixel: accumulate, and queue a mean when it closes a block.
    task automatic fold_pixel(input logic [PIX_W-1:0] pix);
        int f;
        int w;
        int h;
        int out_w;
        int out_h;
        int area;
        t_block_mean m;
        f = clamp_to(int'(factor_reg), 1, MAX_FACTOR);
        w = clamp_to(int'(width_reg), 1, MAX_WIDTH);
        h = clamp_to(int'(height_reg), 1, HEIGHT_LIMIT);
        out_w = w / f;
        out_h = h / f;
        // pixels right of or below the last whole block are dropped
        if (int'(in_col) < out_w * f && int'(in_row) < out_h * f) begin
            run_sum = run_sum + pix;
            if (int'(phase_x) == f - 1) begin
                if (phase_y == '0) col_sum[out_col] = SUM_W'(run_sum);
                else col_sum[out_col] = col_sum[out_col] + run_sum;
                if (int'(phase_y) == f - 1) begin
                    area        = f * f;
                    m.pixel     = PIX_W'((int'(col_sum[out_col]) + area / 2) / area);
                    m.row_end   = (int'(out_col) == out_w - 1);
                    m.frame_end = m.row_end && (int'(in_row) == out_h * f - 1);
                    means_due.push_back(m);
                end
                run_sum = '0;
                out_col = out_col + 1'b1;
                phase_x = '0;
            end else begin
                phase_x = phase_x + 1'b1;
            end
        end
        in_col = in_col + 1'b1;
        if (int'(in_col) >= w) begin
            in_col  = '0;
            phase_x = '0;
            out_col = '0;
            run_sum = '0;
            phase_y = (int'(phase_y) + 1 >= f) ? '0 : phase_y + 1'b1;
            in_row  = in_row + 1'b1;
            if (int'(in_row) >= h) begin
                in_row  = '0;
                phase_y = '0;
            end
        end
    endtask

    task automatic check_mean();
        t_block_mean m;
        if (means_due.size() == 0) begin
            $error("unexpected block mean: pixel_out %0d row_end %0b frame_end %0b",
                   i_mean_data, i_mean_last, i_mean_user);
            o_errors++;
        end else begin
            m = means_due.pop_front();
            o_checked++;
            if (i_mean_data !== m.pixel) begin
                $error("pixel_out mismatch: expected %0d, actual %0d", m.pixel, i_mean_data);
                o_errors++;
            end
            if (i_mean_last !== m.row_end) begin
                $error("row_end mismatch: expected %0b, actual %0b", m.row_end, i_mean_last);
                o_errors++;
            end
            if (i_mean_user !== m.frame_end) begin
                $error("frame_end mismatch: expected %0b, actual %0b",
                       m.frame_end, i_mean_user);
                o_errors++;
            end
        end
    endtask

    // pixel first, then the mean: a mean leaves only after the edge that takes its closing pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            factor_reg = FACTOR_RESET;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            restart_frame();
            means_due.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_write(i_cfg_index, i_cfg_data);
            if (i_pix_valid && i_pix_ready) fold_pixel(i_pix_data);
            if (i_mean_valid && i_mean_ready) check_mean();
        end
        o_pending = means_due.size();
    end

endmodule

[dv/box_average_downscaler_test.sv]
`timescale 1ns / 1ps
// Testbench top of the box-average downscaler: stimulus, stream pacing and verdict.
module box_average_downscaler_test;
    import bxd_pkg::*;

    // unmapped register index; a write there must be ignored and not restart the frame
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Worst pixel holds the input through a merge and a divide plus a pending output; give it room.
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;    // long output hold-off to back the block up
    localparam int PIXEL_TARGET = 1900;

    typedef enum int {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata;    // [7:0] pixel_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [PIX_W-1:0]     m_axis_tdata;    // [7:0] pixel_out
    logic                 m_axis_tlast;    // row_end
    logic                 m_axis_tuser;    // [0] frame_end

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int pixels_sent    = 0;
    int settings_used  = 0;
    int errors;
    int pending;
    int checked;

    box_average_downscaler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    block_mean_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pix_valid  (s_axis_tvalid),
        .i_pix_ready  (s_axis_tready),
        .i_pix_data   (s_axis_tdata),
        .i_mean_valid (m_axis_tvalid),
        .i_mean_ready (m_axis_tready),
        .i_mean_data  (m_axis_tdata),
        .i_mean_last  (m_axis_tlast),
        .i_mean_user  (m_axis_tuser),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("box_average_downscaler_test failed");
        $finish;
    end

    // Output side: random stalls per pacing mode, plus one long hold-off on request.
    // Runs on the falling edge so the DUT sees a stable tready at the rising edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_pacing(input t_pace pace);
        case (pace)
            PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 70; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default:         begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    // Called on a falling edge; returns on the falling edge after the transfer.
    // tvalid stays up between back-to-back pixels, so it is never dropped and raised
    // in the same step.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= PIX_W'($urandom_range(255));   // junk while idle
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // level < 0: random pixels, leaning on 0 and 255; otherwise a flat field
    task automatic send_pixels(input int count, input int level);
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(9);
            if (level >= 0)     send_pixel(PIX_W'(level));
            else if (pick == 0) send_pixel('0);
            else if (pick == 1) send_pixel('1);
            else                send_pixel(PIX_W'($urandom_range(255)));
        end
    endtask

    // Register writes only when the block is drained: no mean outstanding and
    // enough spare cycles for a segment update or a divide still in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits get junk: only the low register bits must matter.
    task automatic set_frame(input logic [FAC_W-1:0] fac, input logic [WID_W-1:0] wid,
                             input logic [HGT_W-1:0] hgt);
        logic [CFG_DAT_W-1:0] word;
        word = CFG_DAT_W'($urandom);
        word[FAC_W-1:0] = fac;
        write_reg(REG_FACTOR, word);
        word = CFG_DAT_W'($urandom);
        word[WID_W-1:0] = wid;
        write_reg(REG_WIDTH, word);
        write_reg(REG_HEIGHT, hgt);
        settings_used++;
    endtask

    initial begin : stimulus
        int phase;
        int pick;
        int fac;
        int eff;
        int wid;
        int hgt;
        int level;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed ----
        // Reset setup is 1024x1024 with f=2: a few pixels give nothing, then the
        // register write below cuts the frame short.
        send_pixels(4, -1);

        // All-zero registers act as ones: 1x1 frame, every pixel is a block that
        // closes both its row and the frame.
        set_frame(5'd0, 13'd0, 15'd0);
        send_pixels(1, 255);
        send_pixels(1, 0);

        // 3x3 with f=2: rightmost column and bottom row fall outside any block.
        set_frame(5'd2, 13'd3, 15'd3);
        send_pixels(9, -1);

        // Frame narrower than one block never yields a mean.
        set_frame(5'd4, 13'd3, 15'd5);
        send_pixels(3, -1);

        // Unmapped index written between the two rows of a 2x2 block: the block
        // must still complete. Sum 2 over area 4 checks round-half-up.
        set_frame(5'd2, 13'd2, 15'd2);
        send_pixels(1, 0);
        send_pixels(1, 1);
        write_reg(REG_SPARE, CFG_DAT_W'($urandom));
        send_pixels(1, 0);
        send_pixels(1, 1);

        // ---- register extremes and back-pressure ----
        // f=1 gives a mean per pixel; holding the output off fills the block up
        // so it has to stall the input stream.
        set_pacing(PACE_FREE);
        set_frame(5'd1, 13'd8, 15'd8);
        hold_request = 1'b1;
        send_pixels(64, -1);

        // Factor above the maximum clamps to 16; height above the limit clamps too.
        set_pacing(PACE_SEND_IDLE);
        set_frame(5'd31, 13'd16, 15'd32767);
        send_pixels(256, -1);

        // Width above the maximum clamps to 4096: no row end within this stretch.
        set_pacing(PACE_RECV_STALL);
        set_frame(5'd1, 13'd8191, 15'd16384);
        send_pixels(200, -1);

        set_pacing(PACE_BOTH);
        set_frame(5'd1, 13'd4096, 15'd1);
        send_pixels(50, -1);
        set_frame(5'd16, 13'd16, 15'd16);
        send_pixels(256, 255);
        set_frame(5'd2, 13'd2, 15'd16384);
        send_pixels(8, -1);

        // ---- random frames ----
        // Mostly whole frames with random content; about a quarter are cut short
        // at a random point and restarted by the next setup.
        phase = 0;
        while (pixels_sent < PIXEL_TARGET) begin
            set_pacing(t_pace'(phase % 4));
            pick = $urandom_range(99);
            if (pick < 4) begin
                fac = $urandom_range(16, 31);
                eff = 16;
                wid = $urandom_range(16, 19);
                hgt = $urandom_range(16, 18);
            end else begin
                fac = (pick < 10) ? 0 : $urandom_range(1, 5);
                eff = (fac == 0) ? 1 : fac;
                wid = $urandom_range(1, 4 * eff + 3);
                hgt = $urandom_range(1, 3 * eff + 2);
            end
            set_frame(FAC_W'(fac), WID_W'(wid), HGT_W'(hgt));
            pick  = $urandom_range(99);
            level = (pick < 12) ? 255 : (pick < 16) ? 0 : -1;
            if ($urandom_range(3) == 0)
                send_pixels($urandom_range(1, wid * hgt), level);
            else if (eff == 16)
                send_pixels(wid * hgt, level);
            else
                send_pixels(wid * hgt * $urandom_range(1, 3), level);
            phase++;
        end

        // ---- drain and verdict ----
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d pixels over %0d frame setups; %0d block means compared.",
                 pixels_sent, settings_used, checked);
        $display("Pacing: free, sender idle, receiver stall, both; one %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("box_average_downscaler_test passed");
        end else begin
            $display("box_average_downscaler_test failed");
        end
        $finish;
    end

endmodule
